// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file. Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define CHK_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define CHK_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/ssk_pkg.sv =====
package ssk_pkg;

    localparam int KEY_W        = 32;
    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 7;
    localparam int OUT_DATA_W   = 16;
    localparam int CAPACITY_DEF = 64;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_MEMBER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Phase of a request as it travels along the row of cells.
    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_INS    = 2'd1;
    localparam logic [1:0] PH_DEL    = 2'd2;
    localparam logic [1:0] PH_FINISH = 2'd3;

    typedef struct packed {
        logic                valid;
        logic [MODE_W-1:0]   mode;
        logic [1:0]          phase;
        logic [STATUS_W-1:0] status;
        logic                no_room;
        logic [KEY_W-1:0]    key;
        logic [KEY_W-1:0]    carry;
    } token_t;

    // A cell hands its key back to its left neighbour while a delete passes it.
    typedef struct packed {
        logic             req;
        logic [KEY_W-1:0] key;
    } pull_t;

endpackage

// ===== rtl/sorted_key_set.sv =====
// Sorted set of signed 32-bit keys held in a row of CAPACITY cells, one key per cell.
// An accepted item passes the launch register and each cell's token register in turn, and
// its result is written to the output register. Each request walks the whole row of cells
// one cell per cycle unless halted; the next item is taken once the result is registered.
// Reset: asynchronous, active low; the set is empty afterwards and no reset pass is needed.
module sorted_key_set #(
    parameter int CAPACITY = ssk_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ssk_pkg::KEY_W-1:0]        s_axis_tdata,  // [31:0] key
    input  logic [ssk_pkg::MODE_W-1:0]       s_axis_tuser,  // [1:0] mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ssk_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // [1:0] status, [8:2] occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = CNT_W + ssk_pkg::OCC_W;

    ssk_pkg::token_t tok_chain  [0:CAPACITY];
    ssk_pkg::pull_t  pull_chain [0:CAPACITY];

    ssk_pkg::token_t               launch_reg;
    ssk_pkg::token_t               launch_next;
    ssk_pkg::token_t               last_tok;
    logic                          busy_reg;
    logic                          busy_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [ssk_pkg::STATUS_W-1:0]  out_status_reg;
    logic [ssk_pkg::STATUS_W-1:0]  out_status_next;
    logic [ssk_pkg::OCC_W-1:0]     out_occ_reg;
    logic [ssk_pkg::OCC_W-1:0]     out_occ_next;
    logic [ssk_pkg::STATUS_W-1:0]  final_status;
    logic [EXT_W-1:0]              occ_ext;
    logic                          in_accept;
    logic                          adv;
    logic                          done;

    assign last_tok   = tok_chain[CAPACITY];
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    // The row only halts while a finished item waits for a full output register.
    assign adv        = !(last_tok.valid && m_axis_tvalid && !m_axis_tready);
    assign done       = last_tok.valid && adv;

    assign s_axis_tready = !busy_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(ssk_pkg::OUT_DATA_W - ssk_pkg::OCC_W - ssk_pkg::STATUS_W)'(0),
                            out_occ_reg, out_status_reg};

    assign tok_chain[0]         = launch_reg;
    assign pull_chain[CAPACITY] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            ssk_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .adv        (adv),
                .count      (count_reg),
                .tok_in     (tok_chain[gi]),
                .tok_out    (tok_chain[gi+1]),
                .right_pull (pull_chain[gi+1]),
                .pull_out   (pull_chain[gi])
            );
        end
    endgenerate

    always_comb
    begin
        launch_next = launch_reg;
        if (in_accept)
        begin
            launch_next.valid   = 1'b1;
            launch_next.mode    = s_axis_tuser;
            launch_next.status  = ssk_pkg::ST_ABSENT;
            launch_next.no_room = count_reg == CNT_W'(CAPACITY);
            launch_next.key     = s_axis_tdata ^ {1'b1, (ssk_pkg::KEY_W - 1)'(0)};
            launch_next.carry   = '0;
            // An unused mode is settled at once and only passes along the row.
            if (s_axis_tuser inside {ssk_pkg::MODE_MEMBER, ssk_pkg::MODE_INSERT,
                                     ssk_pkg::MODE_DELETE})
            begin
                launch_next.phase = ssk_pkg::PH_SEARCH;
            end
            else
            begin
                launch_next.phase = ssk_pkg::PH_FINISH;
            end
        end
        else if (adv)
        begin
            launch_next.valid = 1'b0;
        end
    end

    always_comb
    begin
        final_status = last_tok.status;
        // An insert that passes every cell still searching met a full store.
        if (last_tok.phase == ssk_pkg::PH_SEARCH && last_tok.mode == ssk_pkg::MODE_INSERT)
        begin
            final_status = ssk_pkg::ST_FULL;
        end
    end

    always_comb
    begin
        busy_next       = busy_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        if (in_accept)
        begin
            busy_next = 1'b1;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (done)
        begin
            busy_next       = 1'b0;
            out_valid_next  = 1'b1;
            out_status_next = final_status;
            if (final_status == ssk_pkg::ST_DONE)
            begin
                if (last_tok.mode == ssk_pkg::MODE_INSERT)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else if (last_tok.mode == ssk_pkg::MODE_DELETE)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
        end
    end

    assign occ_ext = EXT_W'(count_next);

    always_comb
    begin
        out_occ_next = out_occ_reg;
        if (done)
        begin
            out_occ_next = occ_ext[ssk_pkg::OCC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg    <= '0;
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            launch_reg    <= launch_next;
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_occ_reg    <= out_occ_next;
    end

endmodule

// ===== rtl/ssk_cell.sv =====
module ssk_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic [CNT_W-1:0] count,
    input  ssk_pkg::token_t tok_in,
    output ssk_pkg::token_t tok_out,
    input  ssk_pkg::pull_t  right_pull,
    output ssk_pkg::pull_t  pull_out
);

    logic [ssk_pkg::KEY_W-1:0] key_reg;
    logic [ssk_pkg::KEY_W-1:0] key_next;
    ssk_pkg::token_t           tok_reg;
    ssk_pkg::token_t           tok_next;
    logic                      occ;
    logic                      lt;
    logic                      eq;

    // Keys are held with the sign bit flipped, so an unsigned compare gives signed order.
    assign occ = CNT_W'(INDEX) < count;
    assign lt  = occ && (key_reg < tok_in.key);
    assign eq  = occ && (key_reg == tok_in.key);

    assign pull_out.req = tok_in.valid && (tok_in.phase == ssk_pkg::PH_DEL);
    assign pull_out.key = key_reg;
    assign tok_out      = tok_reg;

    always_comb
    begin
        tok_next = tok_in;
        key_next = key_reg;
        if (right_pull.req)
        begin
            key_next = right_pull.key;
        end
        if (tok_in.valid)
        begin
            case (tok_in.phase)
                ssk_pkg::PH_SEARCH:
                begin
                    case (tok_in.mode)
                        ssk_pkg::MODE_MEMBER:
                        begin
                            if (eq)
                            begin
                                tok_next.phase  = ssk_pkg::PH_FINISH;
                                tok_next.status = ssk_pkg::ST_DONE;
                            end
                            else if (!lt)
                            begin
                                tok_next.phase = ssk_pkg::PH_FINISH;
                            end
                        end
                        ssk_pkg::MODE_INSERT:
                        begin
                            if (eq)
                            begin
                                tok_next.phase = ssk_pkg::PH_FINISH;
                            end
                            else if (!lt)
                            begin
                                if (tok_in.no_room)
                                begin
                                    tok_next.phase  = ssk_pkg::PH_FINISH;
                                    tok_next.status = ssk_pkg::ST_FULL;
                                end
                                else
                                begin
                                    // Take the new key and carry the displaced one onwards.
                                    key_next        = tok_in.key;
                                    tok_next.status = ssk_pkg::ST_DONE;
                                    tok_next.carry  = key_reg;
                                    tok_next.phase  = occ ? ssk_pkg::PH_INS
                                                          : ssk_pkg::PH_FINISH;
                                end
                            end
                        end
                        ssk_pkg::MODE_DELETE:
                        begin
                            if (eq)
                            begin
                                tok_next.phase  = ssk_pkg::PH_DEL;
                                tok_next.status = ssk_pkg::ST_DONE;
                            end
                            else if (!lt)
                            begin
                                tok_next.phase = ssk_pkg::PH_FINISH;
                            end
                        end
                        default:
                        begin
                            tok_next.phase = ssk_pkg::PH_FINISH;
                        end
                    endcase
                end
                ssk_pkg::PH_INS:
                begin
                    key_next       = tok_in.carry;
                    tok_next.carry = key_reg;
                    if (!occ)
                    begin
                        tok_next.phase = ssk_pkg::PH_FINISH;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg <= key_next;
        end
    end

endmodule

// ===== rtl/ssk_checker.sv =====
`include "assert_macros.svh"

module ssk_checker #(
    parameter int CAPACITY = ssk_pkg::CAPACITY_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ssk_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [ssk_pkg::OCC_W-1:0] OCC_MAX =
        ssk_pkg::OCC_W'(CAPACITY > 127 ? 127 : CAPACITY);

    logic                          out_stall;
    logic [ssk_pkg::STATUS_W-1:0]  out_status;
    logic [ssk_pkg::OCC_W-1:0]     out_occ;

    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_status = m_axis_tdata[ssk_pkg::STATUS_W-1:0];
    assign out_occ    = m_axis_tdata[ssk_pkg::STATUS_W +: ssk_pkg::OCC_W];

    // The block works on one item at a time, so it is never ready straight after an accept.
    `CHK_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "back to back")

    `CHK_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "result changed")

    `CHK_HOLDS(a_status_code, !m_axis_tvalid || out_status <= ssk_pkg::ST_FULL, "unknown status")

    `CHK_HOLDS(a_occ_bound, !m_axis_tvalid || out_occ <= OCC_MAX, "occupancy beyond capacity")

endmodule

bind sorted_key_set ssk_checker #(.CAPACITY(CAPACITY)) u_ssk_checker (.*);
